@@ rtl/hhq_pkg.sv @@
// ----------------------------------------------------------------------------
// hhq_pkg
// Shared types and constants of the heightfield height query block.
// ----------------------------------------------------------------------------
package hhq_pkg;

    localparam int GRID_SIDE_DEF = 257;

    localparam int IDX_W    = 9;
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int EXTENT_W = 31;

    localparam int FRAC_W = 17;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    // half of 65535 * 65536, added before the floor division
    localparam logic signed [63:0] ROUND_HALF = 64'sd2147450880;
    // 65535 * 2^33, keeps the dividend positive
    localparam logic [49:0] DIV_BIAS = 50'h1_FFFE_0000_0000;
    localparam logic signed [36:0] QUOT_BIAS = 37'sh2_0000_0000;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X    = 3'd0,
        REG_MIN_Z    = 3'd1,
        REG_EXTENT   = 3'd2,
        REG_INV_CELL = 3'd3,
        REG_BASE     = 3'd4,
        REG_SCALE    = 3'd5
    } t_reg_idx;

endpackage

@@ rtl/hhq_ram.sv @@
// ----------------------------------------------------------------------------
// hhq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hhq_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/heightfield_height_query.sv @@
// ----------------------------------------------------------------------------
// heightfield_height_query
// Grid of 16-bit height samples with triangle interpolated height queries.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries one word: op 0 writes one
// sample at (col, row), op 1 queries the world height at (pos_x, pos_z).
// Every word gives exactly one result word on o_out_valid / i_out_stall:
// zero for writes, base height with inside clear for positions outside the
// footprint, otherwise the interpolated, scaled and saturated height.
// Configuration registers are written through i_cfg_we / i_cfg_index /
// i_cfg_wdata, by the user only while no word is in flight; the block does not enforce this.
// One word is accepted per cycle while o_in_stall is low. The samples sit
// in four RAM banks split by row and column parity, so the four corners of
// a cell are read in the same cycle, and a write passes the same pipeline
// stage as the reads, in order.
// Reset clears the pipeline and loads the register defaults; sample memory
// is not cleared and must be written before it is read.
// When the receiver stalls, the result holds and stages behind it keep
// filling until the pipeline is full, then o_in_stall rises.
// ----------------------------------------------------------------------------
module heightfield_height_query
    import hhq_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic [IDX_W-1:0]            i_col_index,
    input  logic [IDX_W-1:0]            i_row_index,
    input  logic [SAMPLE_W-1:0]         i_sample_value,
    input  logic signed [POS_W-1:0]     i_pos_x,
    input  logic signed [POS_W-1:0]     i_pos_z,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [31:0]          o_height_out,
    output logic                        o_inside_res,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_wdata
);

    localparam int CW = $clog2(GRID_SIDE);
    localparam int HALF = (GRID_SIDE + 1) / 2;
    localparam int BANK_DEPTH = HALF * HALF;
    localparam int AW = $clog2(BANK_DEPTH);
    localparam int NS = 11;

    typedef struct packed {
        logic [CW-1:0]     idx;
        logic [FRAC_W-1:0] frac;
    } t_cell;

    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] c,
                                             input logic [CW-1:0] r);
        logic [31:0] t;
        t = 32'(r >> 1) * 32'(HALF) + 32'(c >> 1);
        return t[AW-1:0];
    endfunction

    function automatic t_cell f_cell(input logic [63:0] g);
        t_cell cl;
        if (g[63:32] > 32'(GRID_SIDE - 2)) begin
            cl.idx  = CW'(GRID_SIDE - 2);
            cl.frac = FRAC_ONE;
        end else begin
            cl.idx  = CW'(g[63:32]);
            cl.frac = {1'b0, g[31:16]};
        end
        return cl;
    endfunction

    // configuration
    logic signed [31:0]   r_min_x, r_min_z, r_base, r_scale;
    logic [EXTENT_W-1:0]  r_extent;
    logic [31:0]          r_inv_cell;

    // pipeline control
    logic [NS:1]   r_v;
    logic [NS+1:1] en;
    logic [NS:1]   r_op;
    logic [NS:1]   r_ins;

    // stage payload
    logic [IDX_W-1:0]    r1_col, r1_row, r2_col, r2_row;
    logic [SAMPLE_W-1:0] r1_smp, r2_smp, r3_smp;
    logic signed [32:0]  r1_dx, r1_dz;
    logic [63:0]         r2_gx, r2_gz;
    logic [CW-1:0]       r3_i, r3_j;
    logic [FRAC_W-1:0]   r3_fx, r3_fz, r4_fx, r4_fz;
    logic                r3_wok, r4_ip, r4_jp;
    logic [31:0]         r5_pa, r5_pb, r5_pc, r6_v;
    logic signed [63:0]  r7_p, r8_num;
    logic [33:0]         r9_hi;
    logic [34:0]         r9_c, r10_qq;
    logic signed [31:0]  r_height;

    logic                n_ins2;
    t_cell               cx, cz;
    logic [15:0]         q [4];
    logic [3:0]          bank_we;
    logic [AW-1:0]       raddr [4];
    logic [AW-1:0]       waddr;
    logic                ge;
    logic [15:0]         hb;
    logic [FRAC_W-1:0]   wa, wb, wc;
    logic signed [32:0]  vs;
    logic signed [64:0]  p_full;
    logic [47:0]         a_sh;
    logic [49:0]         b_val;
    logic [18:0]         ch;
    logic [19:0]         d_val;
    logic [16:0]         e_val;
    logic                corr;
    logic signed [36:0]  res;
    logic signed [31:0]  n_height;

    always_comb begin
        en[NS+1] = !i_out_stall;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_in_stall = !en[1];

    // four banks addressed by {row parity, column parity}
    assign waddr = f_addr(r3_i, r3_j);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [CW-1:0] bc, br;
        assign bc = r3_i + CW'(r3_i[0] ^ b[0]);
        assign br = r3_j + CW'(r3_j[0] ^ b[1]);
        assign raddr[b] = f_addr(bc, br);
        assign bank_we[b] = en[4] && r_v[3] && (r_op[3] == OP_WRITE) && r3_wok
                            && (r3_i[0] == b[0]) && (r3_j[0] == b[1]);

        hhq_ram #(
            .DATA_W (SAMPLE_W),
            .DEPTH  (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (bank_we[b]),
            .i_waddr (waddr),
            .i_wdata (r3_smp),
            .i_re    (en[4]),
            .i_raddr (raddr[b]),
            .o_rdata (q[b])
        );
    end

    always_comb begin
        n_ins2 = !r1_dx[32] && (r1_dx <= $signed({2'b00, r_extent}))
                 && !r1_dz[32] && (r1_dz <= $signed({2'b00, r_extent}));
        cx = f_cell(r2_gx);
        cz = f_cell(r2_gz);

        ge = (r4_fx >= r4_fz);
        wa = FRAC_ONE - (ge ? r4_fx : r4_fz);
        wb = ge ? (r4_fx - r4_fz) : (r4_fz - r4_fx);
        wc = ge ? r4_fz : r4_fx;
        hb = ge ? q[{r4_jp, ~r4_ip}] : q[{~r4_jp, r4_ip}];

        vs = $signed({1'b0, r6_v});
        p_full = vs * r_scale;

        // floor divide by 65535 * 65536 through digit folding
        a_sh  = r8_num[63:16];
        b_val = {{2{a_sh[47]}}, a_sh} + DIV_BIAS;

        ch    = r9_c[34:16];
        d_val = {1'b0, ch} + {4'b0000, r9_c[15:0]};
        e_val = {13'd0, d_val[19:16]} + {1'b0, d_val[15:0]};
        corr  = (e_val >= 17'd65535);

        res = $signed({{5{r_base[31]}}, r_base}) + ($signed({2'b00, r10_qq}) - QUOT_BIAS);
        if (res > 37'sd2147483647) begin
            n_height = 32'sh7FFF_FFFF;
        end else if (res < -37'sd2147483648) begin
            n_height = 32'sh8000_0000;
        end else begin
            n_height = res[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v        <= '0;
            r_min_x    <= '0;
            r_min_z    <= '0;
            r_extent   <= 31'd16777216;
            r_inv_cell <= 32'd65536;
            r_base     <= '0;
            r_scale    <= 32'sd65536;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_MIN_X:    r_min_x    <= i_cfg_wdata;
                    REG_MIN_Z:    r_min_z    <= i_cfg_wdata;
                    REG_EXTENT:   r_extent   <= i_cfg_wdata[EXTENT_W-1:0];
                    REG_INV_CELL: r_inv_cell <= i_cfg_wdata;
                    REG_BASE:     r_base     <= i_cfg_wdata;
                    REG_SCALE:    r_scale    <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (en[1]) begin
                r_v[1] <= i_in_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_op[1]  <= i_op;
            r_ins[1] <= 1'b0;
            r1_col   <= i_col_index;
            r1_row   <= i_row_index;
            r1_smp   <= i_sample_value;
            r1_dx    <= $signed({i_pos_x[31], i_pos_x}) - $signed({r_min_x[31], r_min_x});
            r1_dz    <= $signed({i_pos_z[31], i_pos_z}) - $signed({r_min_z[31], r_min_z});
        end
        if (en[2]) begin
            r_op[2]  <= r_op[1];
            r_ins[2] <= n_ins2;
            r2_col   <= r1_col;
            r2_row   <= r1_row;
            r2_smp   <= r1_smp;
            r2_gx    <= r1_dx[31:0] * r_inv_cell;
            r2_gz    <= r1_dz[31:0] * r_inv_cell;
        end
        if (en[3]) begin
            r_op[3]  <= r_op[2];
            r_ins[3] <= r_ins[2];
            r3_smp   <= r2_smp;
            r3_wok   <= (32'(r2_col) < 32'(GRID_SIDE)) && (32'(r2_row) < 32'(GRID_SIDE));
            r3_fx    <= cx.frac;
            r3_fz    <= cz.frac;
            if (r_op[2] == OP_WRITE) begin
                r3_i <= CW'(r2_col);
                r3_j <= CW'(r2_row);
            end else begin
                r3_i <= cx.idx;
                r3_j <= cz.idx;
            end
        end
        if (en[4]) begin
            r_op[4]  <= r_op[3];
            r_ins[4] <= r_ins[3];
            r4_fx    <= r3_fx;
            r4_fz    <= r3_fz;
            r4_ip    <= r3_i[0];
            r4_jp    <= r3_j[0];
        end
        if (en[5]) begin
            r_op[5]  <= r_op[4];
            r_ins[5] <= r_ins[4];
            r5_pa    <= 32'(q[{r4_jp, r4_ip}] * wa);
            r5_pb    <= 32'(hb * wb);
            r5_pc    <= 32'(q[{~r4_jp, ~r4_ip}] * wc);
        end
        if (en[6]) begin
            r_op[6]  <= r_op[5];
            r_ins[6] <= r_ins[5];
            r6_v     <= r5_pa + r5_pb + r5_pc;
        end
        if (en[7]) begin
            r_op[7]  <= r_op[6];
            r_ins[7] <= r_ins[6];
            r7_p     <= p_full[63:0];
        end
        if (en[8]) begin
            r_op[8]  <= r_op[7];
            r_ins[8] <= r_ins[7];
            r8_num   <= r7_p + ROUND_HALF;
        end
        if (en[9]) begin
            r_op[9]  <= r_op[8];
            r_ins[9] <= r_ins[8];
            r9_hi    <= b_val[49:16];
            r9_c     <= {1'b0, b_val[49:16]} + {19'd0, b_val[15:0]};
        end
        if (en[10]) begin
            r_op[10]  <= r_op[9];
            r_ins[10] <= r_ins[9];
            r10_qq    <= {1'b0, r9_hi} + {16'd0, ch} + 35'(d_val[19:16]) + 35'(corr);
        end
        if (en[11]) begin
            r_op[11]  <= r_op[10];
            r_ins[11] <= r_ins[10];
            if (r_op[10] == OP_WRITE) begin
                r_height <= '0;
            end else if (!r_ins[10]) begin
                r_height <= r_base;
            end else begin
                r_height <= n_height;
            end
        end
    end

    assign o_out_valid  = r_v[NS];
    assign o_height_out = r_height;
    assign o_inside_res = r_ins[NS] && (r_op[NS] == OP_QUERY);

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && (r_v == '1)))
        else $error("input stalled while pipeline has room");

    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bank_we != '0) |-> (r_v[3] && (r_op[3] == OP_WRITE) && $onehot(bank_we)))
        else $error("bank write without a write word in the access stage");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && (r_op[4] == OP_QUERY)) |-> ((r4_fx <= FRAC_ONE) && (r4_fz <= FRAC_ONE)))
        else $error("cell fraction above one");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_op[NS] == OP_WRITE)) |-> ((o_height_out == '0) && !o_inside_res))
        else $error("write word gave a nonzero result");

endmodule
